[hdl/amog_pkg.sv]
package amog_pkg;

  // History store geometry.
  localparam int unsigned HistoryDepth = 600;
  localparam int unsigned HistIdxW     = $clog2(HistoryDepth);
  localparam int unsigned CntW         = $clog2(HistoryDepth + 1);

  // Field and register widths.
  localparam int unsigned CmdW       = 2;
  localparam int unsigned SampleW    = 12;
  localparam int unsigned SensW      = 12;
  localparam int unsigned LimitW     = 12;
  localparam int unsigned RunW       = 18;
  localparam int unsigned BlankW     = 12;
  localparam int unsigned PeriodW    = 10;
  localparam int unsigned CauseW     = 2;
  localparam int unsigned FillLevelW = 10;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 18;

  // Datapath widths of the adaptive check.
  localparam int unsigned SumW   = SampleW + CntW;
  localparam int unsigned ProdLW = SampleW + CntW;
  localparam int unsigned ProdRW = SumW + SensW;

  // Division by three through a reciprocal, exact for dividends below 2**RecipShift.
  localparam int unsigned RecipShift = 17;
  localparam int unsigned Recip3     = (1 << RecipShift) / 3 + 1;
  localparam int unsigned CutProdW   = CntW + 1 + RecipShift;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgSensitivity = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgAbsLimit    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRunTimeout  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgBlankTicks  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSamplePer   = 3'd4;

  // Configuration reset values.
  localparam logic [SensW-1:0]   SensReset    = 12'd384;
  localparam logic [LimitW-1:0]  LimitReset   = 12'd4095;
  localparam logic [RunW-1:0]    TimeoutReset = 18'd120000;
  localparam logic [BlankW-1:0]  BlankReset   = 12'd500;
  localparam logic [PeriodW-1:0] PeriodReset  = 10'd50;

  // Motor commands.
  localparam logic [CmdW-1:0] CmdStop = 2'd0;

  // Trip causes.
  localparam logic [CauseW-1:0] CauseNone     = 2'd0;
  localparam logic [CauseW-1:0] CauseTimeout  = 2'd1;
  localparam logic [CauseW-1:0] CauseAbsolute = 2'd2;
  localparam logic [CauseW-1:0] CauseAdaptive = 2'd3;

  typedef enum logic [2:0] {
    StIdle,
    StEval,
    StSum,
    StMulA,
    StMulB,
    StDecide,
    StEmit
  } state_e;

  // Adds two ring indexes and wraps once around the history depth.
  function automatic logic [HistIdxW-1:0] wrap_add(input logic [HistIdxW-1:0] a,
                                                   input logic [HistIdxW-1:0] b);
    logic [HistIdxW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (HistIdxW + 1)'(HistoryDepth)) begin
      s = s - (HistIdxW + 1)'(HistoryDepth);
    end
    return s[HistIdxW-1:0];
  endfunction

endpackage

[hdl/amog_ram.sv]
module amog_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[hdl/adaptive_motor_overcurrent_guard_unit.sv]
// Flow: a word that skips the adaptive check passes StEval and StEmit before it reaches
// the output register; a checked word also passes StSum, StMulA, StMulB and StDecide,
// and StSum reads cut samples (cut is two thirds of the stored count, at most 400 with
// 600 samples) one by one, since one RAM read port feeds the sum. One word in flight:
// a new word is taken only in StIdle, and StEmit waits while the output is held off.
// Reset clears timers, flags, fill count and configuration; the history RAM is not cleared.
module adaptive_motor_overcurrent_guard_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [amog_pkg::CmdW-1:0]      motor_command_i,
  input  logic [amog_pkg::SampleW-1:0]   current_sample_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           stop_request_o,
  output logic [amog_pkg::CauseW-1:0]    trip_cause_o,
  output logic                           end_stop_flag_o,
  output logic [amog_pkg::FillLevelW-1:0] fill_level_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [amog_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [amog_pkg::CfgDataW-1:0]  cfg_data_i
);

  amog_pkg::state_e state_q, state_d;

  // Configuration registers.
  logic [amog_pkg::SensW-1:0]   sens_q;
  logic [amog_pkg::LimitW-1:0]  limit_q;
  logic [amog_pkg::RunW-1:0]    timeout_q;
  logic [amog_pkg::BlankW-1:0]  blank_ticks_q;
  logic [amog_pkg::PeriodW-1:0] period_q;

  // Guard state.
  logic [amog_pkg::RunW-1:0]     run_q, run_d;
  logic [amog_pkg::BlankW-1:0]   blank_q, blank_d;
  logic [amog_pkg::PeriodW-1:0]  smp_q, smp_d;
  logic                          blank_act_q, blank_act_d;
  logic                          running_q, running_d;
  logic                          halted_q, halted_d;
  logic                          latch_q, latch_d;
  logic [amog_pkg::CntW-1:0]     fill_q, fill_d;
  logic [amog_pkg::HistIdxW-1:0] oldest_q, oldest_d;

  // Working registers of one word.
  logic [amog_pkg::CmdW-1:0]     cmd_q, cmd_d;
  logic [amog_pkg::SampleW-1:0]  sample_q, sample_d;
  logic                          res_stop_q, res_stop_d;
  logic [amog_pkg::CauseW-1:0]   res_cause_q, res_cause_d;
  logic [amog_pkg::SumW-1:0]     sum_q, sum_d;
  logic [amog_pkg::CntW-1:0]     cut_q, cut_d;
  logic [amog_pkg::CntW-1:0]     issue_q, issue_d;
  logic [amog_pkg::HistIdxW-1:0] rd_ptr_q, rd_ptr_d;
  logic                          rd_pend_q, rd_pend_d;
  logic [amog_pkg::ProdLW-1:0]   prod_l_q, prod_l_d;
  logic [amog_pkg::ProdRW-1:0]   prod_r_q, prod_r_d;

  // Output register.
  logic                            out_valid_q, out_valid_d;
  logic                            out_stop_q;
  logic [amog_pkg::CauseW-1:0]     out_cause_q;
  logic                            out_latch_q;
  logic [amog_pkg::FillLevelW-1:0] out_fill_q;
  logic                            out_free;

  // History RAM ports.
  logic                          ram_we;
  logic [amog_pkg::HistIdxW-1:0] ram_waddr;
  logic [amog_pkg::HistIdxW-1:0] ram_raddr;
  logic [amog_pkg::SampleW-1:0]  ram_rdata;

  // Cut size: two thirds of the stored count, at least one.
  logic [amog_pkg::CutProdW-1:0] cut_prod;
  logic [amog_pkg::CntW-1:0]     cut_raw;
  logic [amog_pkg::CntW-1:0]     cut_calc;

  logic eval_adapt;
  logic sum_done;
  logic adapt_trip;

  assign cut_prod = amog_pkg::CutProdW'({fill_q, 1'b0}) *
                    amog_pkg::CutProdW'(amog_pkg::Recip3);
  assign cut_raw  = cut_prod[amog_pkg::RecipShift +: amog_pkg::CntW];
  assign cut_calc = (cut_raw == '0) ? amog_pkg::CntW'(1) : cut_raw;

  assign adapt_trip = amog_pkg::ProdRW'({prod_l_q, 8'b0}) > prod_r_q;
  assign out_free   = !out_valid_q || out_ready_i;

  amog_ram #(
    .Width (amog_pkg::SampleW),
    .Depth (amog_pkg::HistoryDepth)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (sample_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      amog_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = amog_pkg::StEval;
        end
      end
      amog_pkg::StEval: begin
        state_d = eval_adapt ? amog_pkg::StSum : amog_pkg::StEmit;
      end
      amog_pkg::StSum: begin
        if (sum_done) begin
          state_d = amog_pkg::StMulA;
        end
      end
      amog_pkg::StMulA:   state_d = amog_pkg::StMulB;
      amog_pkg::StMulB:   state_d = amog_pkg::StDecide;
      amog_pkg::StDecide: state_d = amog_pkg::StEmit;
      amog_pkg::StEmit: begin
        if (out_free) begin
          state_d = amog_pkg::StIdle;
        end
      end
      default: state_d = amog_pkg::StIdle;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    in_ready_o  = (state_q == amog_pkg::StIdle);
    out_valid_d = out_valid_q && !out_ready_i;
    if (state_q == amog_pkg::StEmit && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  // Datapath.
  always_comb begin
    run_d       = run_q;
    blank_d     = blank_q;
    smp_d       = smp_q;
    blank_act_d = blank_act_q;
    running_d   = running_q;
    halted_d    = halted_q;
    latch_d     = latch_q;
    fill_d      = fill_q;
    oldest_d    = oldest_q;
    cmd_d       = cmd_q;
    sample_d    = sample_q;
    res_stop_d  = res_stop_q;
    res_cause_d = res_cause_q;
    sum_d       = sum_q;
    cut_d       = cut_q;
    issue_d     = issue_q;
    rd_ptr_d    = rd_ptr_q;
    rd_pend_d   = 1'b0;
    prod_l_d    = prod_l_q;
    prod_r_d    = prod_r_q;
    ram_we      = 1'b0;
    ram_waddr   = oldest_q;
    ram_raddr   = rd_ptr_q;
    eval_adapt  = 1'b0;
    sum_done    = 1'b0;

    case (state_q)
      amog_pkg::StIdle: begin
        if (in_valid_i) begin
          cmd_d    = motor_command_i;
          sample_d = current_sample_i;
        end
      end

      amog_pkg::StEval: begin
        res_stop_d  = 1'b0;
        res_cause_d = amog_pkg::CauseNone;
        if (cmd_q == amog_pkg::CmdStop) begin
          blank_act_d = 1'b0;
          running_d   = 1'b0;
          halted_d    = 1'b0;
        end else if (!halted_q) begin
          if (!running_q) begin
            // Start from stop: fresh timers and an empty history.
            running_d   = 1'b1;
            blank_act_d = 1'b1;
            run_d       = '0;
            blank_d     = '0;
            smp_d       = '0;
            fill_d      = '0;
            oldest_d    = '0;
            latch_d     = 1'b0;
          end else begin
            run_d   = (run_q == '1) ? run_q : run_q + 1'b1;
            blank_d = (blank_q == '1) ? blank_q : blank_q + 1'b1;
            smp_d   = (smp_q == '1) ? smp_q : smp_q + 1'b1;
          end

          if (run_d >= timeout_q) begin
            halted_d    = 1'b1;
            running_d   = 1'b0;
            blank_act_d = 1'b0;
            latch_d     = 1'b0;
            res_stop_d  = 1'b1;
            res_cause_d = amog_pkg::CauseTimeout;
          end else if (sample_q > limit_q) begin
            halted_d    = 1'b1;
            running_d   = 1'b0;
            blank_act_d = 1'b0;
            latch_d     = 1'b1;
            res_stop_d  = 1'b1;
            res_cause_d = amog_pkg::CauseAbsolute;
          end else if (!(blank_act_d && blank_d < blank_ticks_q)) begin
            // The sample timer restarts on the tick blanking ends.
            if (blank_act_d) begin
              blank_act_d = 1'b0;
              smp_d       = '0;
            end
            if (smp_d >= period_q) begin
              smp_d = '0;
              if (fill_d == '0) begin
                ram_we    = 1'b1;
                ram_waddr = oldest_d;
                fill_d    = amog_pkg::CntW'(1);
              end else begin
                eval_adapt = 1'b1;
                sum_d      = '0;
                issue_d    = '0;
                rd_ptr_d   = oldest_q;
                cut_d      = cut_calc;
              end
            end
          end
        end
      end

      amog_pkg::StSum: begin
        // One read issued per cycle; its data returns in the following cycle.
        if (issue_q != cut_q) begin
          ram_raddr = rd_ptr_q;
          rd_ptr_d  = amog_pkg::wrap_add(rd_ptr_q, amog_pkg::HistIdxW'(1));
          issue_d   = issue_q + 1'b1;
          rd_pend_d = 1'b1;
        end
        if (rd_pend_q) begin
          sum_d = sum_q + amog_pkg::SumW'(ram_rdata);
        end
        sum_done = (issue_q == cut_q) && !rd_pend_q;
      end

      amog_pkg::StMulA: begin
        prod_l_d = amog_pkg::ProdLW'(sample_q) * amog_pkg::ProdLW'(cut_q);
      end

      amog_pkg::StMulB: begin
        prod_r_d = amog_pkg::ProdRW'(sum_q) * amog_pkg::ProdRW'(sens_q);
      end

      amog_pkg::StDecide: begin
        if (adapt_trip) begin
          halted_d    = 1'b1;
          running_d   = 1'b0;
          blank_act_d = 1'b0;
          latch_d     = 1'b1;
          res_stop_d  = 1'b1;
          res_cause_d = amog_pkg::CauseAdaptive;
        end else if (fill_q < amog_pkg::CntW'(amog_pkg::HistoryDepth)) begin
          ram_we    = 1'b1;
          ram_waddr = amog_pkg::wrap_add(oldest_q, amog_pkg::HistIdxW'(fill_q));
          fill_d    = fill_q + 1'b1;
        end else begin
          // Full store: overwrite the oldest sample and advance past it.
          ram_we    = 1'b1;
          ram_waddr = oldest_q;
          oldest_d  = amog_pkg::wrap_add(oldest_q, amog_pkg::HistIdxW'(1));
        end
      end

      amog_pkg::StEmit: begin
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= amog_pkg::StIdle;
      run_q       <= '0;
      blank_q     <= '0;
      smp_q       <= '0;
      blank_act_q <= 1'b0;
      running_q   <= 1'b0;
      halted_q    <= 1'b0;
      latch_q     <= 1'b0;
      fill_q      <= '0;
      oldest_q    <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_q       <= run_d;
      blank_q     <= blank_d;
      smp_q       <= smp_d;
      blank_act_q <= blank_act_d;
      running_q   <= running_d;
      halted_q    <= halted_d;
      latch_q     <= latch_d;
      fill_q      <= fill_d;
      oldest_q    <= oldest_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    sample_q    <= sample_d;
    res_stop_q  <= res_stop_d;
    res_cause_q <= res_cause_d;
    sum_q       <= sum_d;
    cut_q       <= cut_d;
    issue_q     <= issue_d;
    rd_ptr_q    <= rd_ptr_d;
    prod_l_q    <= prod_l_d;
    prod_r_q    <= prod_r_d;
    if (state_q == amog_pkg::StEmit && out_free) begin
      out_stop_q  <= res_stop_q;
      out_cause_q <= res_cause_q;
      out_latch_q <= latch_q;
      out_fill_q  <= amog_pkg::FillLevelW'(fill_q);
    end
  end

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q        <= amog_pkg::SensReset;
      limit_q       <= amog_pkg::LimitReset;
      timeout_q     <= amog_pkg::TimeoutReset;
      blank_ticks_q <= amog_pkg::BlankReset;
      period_q      <= amog_pkg::PeriodReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        amog_pkg::CfgSensitivity: sens_q        <= cfg_data_i[amog_pkg::SensW-1:0];
        amog_pkg::CfgAbsLimit:    limit_q       <= cfg_data_i[amog_pkg::LimitW-1:0];
        amog_pkg::CfgRunTimeout:  timeout_q     <= cfg_data_i[amog_pkg::RunW-1:0];
        amog_pkg::CfgBlankTicks:  blank_ticks_q <= cfg_data_i[amog_pkg::BlankW-1:0];
        amog_pkg::CfgSamplePer:   period_q      <= cfg_data_i[amog_pkg::PeriodW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stop_request_o  = out_stop_q;
  assign trip_cause_o    = out_cause_q;
  assign end_stop_flag_o = out_latch_q;
  assign fill_level_o    = out_fill_q;

endmodule

[verif/tb_adaptive_motor_overcurrent_guard_unit.sv]
module tb_adaptive_motor_overcurrent_guard_unit;
  import amog_pkg::*;

  localparam logic [CmdW-1:0] CmdOpen  = 2'd1;
  localparam logic [CmdW-1:0] CmdClose = 2'd2;
  localparam logic [CmdW-1:0] CmdGoto  = 2'd3;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned HoldAtWord = 40;
  localparam int unsigned HoldCycles = 3000;
  localparam int unsigned DrainPause = 16;

  typedef struct {
    logic [CmdW-1:0]    cmd;
    logic [SampleW-1:0] sample;
  } tick_word_t;

  typedef struct packed {
    logic                  stop;
    logic [CauseW-1:0]     cause;
    logic                  end_stop;
    logic [FillLevelW-1:0] fill;
  } guard_word_t;

  logic                  clk_i            = 1'b0;
  logic                  rst_ni           = 1'b0;
  logic                  in_valid_i       = 1'b0;
  logic                  in_ready_o;
  logic [CmdW-1:0]       motor_command_i  = CmdStop;
  logic [SampleW-1:0]    current_sample_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i      = 1'b0;
  logic                  stop_request_o;
  logic [CauseW-1:0]     trip_cause_o;
  logic                  end_stop_flag_o;
  logic [FillLevelW-1:0] fill_level_o;
  logic                  cfg_valid_i      = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i      = CfgSensitivity;
  logic [CfgDataW-1:0]   cfg_data_i       = '0;

  adaptive_motor_overcurrent_guard_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .motor_command_i  (motor_command_i),
    .current_sample_i (current_sample_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .stop_request_o   (stop_request_o),
    .trip_cause_o     (trip_cause_o),
    .end_stop_flag_o  (end_stop_flag_o),
    .fill_level_o     (fill_level_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Register copies used by the guard predictor.
  logic [SensW-1:0]   cfg_sens    = SensReset;
  logic [LimitW-1:0]  cfg_limit   = LimitReset;
  logic [RunW-1:0]    cfg_timeout = TimeoutReset;
  logic [BlankW-1:0]  cfg_blank   = BlankReset;
  logic [PeriodW-1:0] cfg_period  = PeriodReset;

  // Guard state as the predictor sees it.
  logic [SampleW-1:0]  hist_mem [HistoryDepth];
  logic [CntW-1:0]     fill_cnt   = '0;
  logic [HistIdxW-1:0] oldest_idx = '0;
  logic [RunW-1:0]     run_cnt    = '0;
  logic [BlankW-1:0]   blank_cnt  = '0;
  logic [PeriodW-1:0]  period_cnt = '0;
  logic                blanking   = 1'b0;
  logic                running    = 1'b0;
  logic                halted     = 1'b0;
  logic                end_stop   = 1'b0;

  tick_word_t  pending_words [$];
  guard_word_t expected_words [$];

  int unsigned send_idle_pct  = 0;
  int unsigned stall_pct      = 0;
  int unsigned words_accepted = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned hold_left      = 0;
  logic        hold_done      = 1'b0;
  logic        word_taken     = 1'b0;

  function automatic guard_word_t advance_guard(input logic [CmdW-1:0] cmd,
                                                input logic [SampleW-1:0] sample);
    guard_word_t       w;
    logic [CauseW-1:0] cause;
    int unsigned       cut;
    longint unsigned   acc;
    longint unsigned   lhs;
    longint unsigned   rhs;
    cause = CauseNone;
    if (cmd == CmdStop) begin
      blanking = 1'b0;
      running  = 1'b0;
      halted   = 1'b0;
    end else if (!halted) begin
      if (!running) begin
        running    = 1'b1;
        blanking   = 1'b1;
        run_cnt    = '0;
        blank_cnt  = '0;
        period_cnt = '0;
        fill_cnt   = '0;
        oldest_idx = '0;
        end_stop   = 1'b0;
      end else begin
        if (run_cnt != '1) run_cnt++;
        if (blank_cnt != '1) blank_cnt++;
        if (period_cnt != '1) period_cnt++;
      end
      if (run_cnt >= cfg_timeout) begin
        cause = CauseTimeout;
      end else if (sample > cfg_limit) begin
        cause = CauseAbsolute;
      end else if (!(blanking && blank_cnt < cfg_blank)) begin
        // The sample timer restarts on the tick that blanking ends.
        if (blanking) begin
          blanking   = 1'b0;
          period_cnt = '0;
        end
        if (period_cnt >= cfg_period) begin
          period_cnt = '0;
          if (fill_cnt == 0) begin
            hist_mem[oldest_idx] = sample;
            fill_cnt = 1;
          end else begin
            cut = (int'(fill_cnt) * 2) / 3;
            if (cut == 0) cut = 1;
            acc = 0;
            for (int unsigned i = 0; i < cut; i++) begin
              acc += hist_mem[(int'(oldest_idx) + i) % HistoryDepth];
            end
            lhs = sample;
            lhs = lhs * cut * 256;
            rhs = acc * cfg_sens;
            if (lhs > rhs) begin
              cause = CauseAdaptive;
            end else if (fill_cnt < HistoryDepth) begin
              hist_mem[(int'(oldest_idx) + int'(fill_cnt)) % HistoryDepth] = sample;
              fill_cnt++;
            end else begin
              hist_mem[oldest_idx] = sample;
              oldest_idx = HistIdxW'((int'(oldest_idx) + 1) % HistoryDepth);
            end
          end
        end
      end
      if (cause != CauseNone) begin
        halted   = 1'b1;
        running  = 1'b0;
        blanking = 1'b0;
        end_stop = (cause != CauseTimeout);
      end
    end
    w.stop     = (cause != CauseNone);
    w.cause    = cause;
    w.end_stop = end_stop;
    w.fill     = FillLevelW'(fill_cnt);
    return w;
  endfunction

  // Input side: words are accepted at the rising edge and replaced at the falling edge.
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      expected_words.push_back(advance_guard(motor_command_i, current_sample_i));
      words_accepted <= words_accepted + 1;
      word_taken     <= 1'b1;
    end
  end

  always @(negedge clk_i) begin
    tick_word_t t;
    if (!in_valid_i || word_taken) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        t = pending_words.pop_front();
        in_valid_i       <= 1'b1;
        motor_command_i  <= t.cmd;
        current_sample_i <= t.sample;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    word_taken <= 1'b0;
  end

  // Output side, including one long hold-off that lets the guard back up its input.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (!hold_done && words_accepted >= HoldAtWord) begin
      hold_done   <= 1'b1;
      hold_left   <= HoldCycles;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    guard_word_t got;
    guard_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {stop_request_o, trip_cause_o, end_stop_flag_o, fill_level_o};
      if (expected_words.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("%0t: unexpected result stop %0d cause %0d end_stop %0d fill %0d",
                   $time, got.stop, got.cause, got.end_stop, got.fill);
        end
        mismatch_count++;
      end else begin
        want = expected_words.pop_front();
        if (got.stop !== want.stop || got.cause !== want.cause ||
            got.end_stop !== want.end_stop || got.fill !== want.fill) begin
          if (mismatch_count < 10) begin
            $display("%0t: mismatch (expected/actual) stop %0d/%0d cause %0d/%0d",
                     $time, want.stop, got.stop, want.cause, got.cause);
            $display("    end_stop %0d/%0d fill %0d/%0d",
                     want.end_stop, got.end_stop, want.fill, got.fill);
          end
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb_adaptive_motor_overcurrent_guard_unit failed");
      $finish;
    end
  end

  task automatic queue_tick(input logic [CmdW-1:0] cmd, input logic [SampleW-1:0] sample);
    tick_word_t t;
    t.cmd    = cmd;
    t.sample = sample;
    pending_words.push_back(t);
  endtask

  // Waits until every queued word has been sent and answered, then lets the guard settle.
  task automatic drain_guard();
    while (pending_words.size() != 0 || in_valid_i || expected_words.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainPause) @(posedge clk_i);
  endtask

  task automatic write_guard_reg(input logic [CfgIdxW-1:0] idx, input int unsigned data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CfgDataW'(data);
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgSensitivity: cfg_sens    = SensW'(data);
      CfgAbsLimit:    cfg_limit   = LimitW'(data);
      CfgRunTimeout:  cfg_timeout = RunW'(data);
      CfgBlankTicks:  cfg_blank   = BlankW'(data);
      CfgSamplePer:   cfg_period  = PeriodW'(data);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic program_guard(input int unsigned sens, input int unsigned limit,
                               input int unsigned timeout, input int unsigned blank,
                               input int unsigned period);
    write_guard_reg(CfgSensitivity, sens);
    write_guard_reg(CfgAbsLimit, limit);
    write_guard_reg(CfgRunTimeout, timeout);
    write_guard_reg(CfgBlankTicks, blank);
    write_guard_reg(CfgSamplePer, period);
  endtask

  // Motor runs: a stop, then a start and a steady current around a base level, with
  // occasional spikes and the odd stop in the middle of a run.
  task automatic queue_runs(input int unsigned total, input int lo, input int hi);
    int unsigned      n;
    int unsigned      len;
    int               base;
    int               s;
    logic [CmdW-1:0]  cmd;
    n = 0;
    while (n < total) begin
      queue_tick(CmdStop, SampleW'($urandom));
      n++;
      len  = $urandom_range(4, 40);
      base = $urandom_range(lo, hi);
      for (int unsigned k = 0; k < len; k++) begin
        cmd = ($urandom_range(29) == 0) ? CmdStop : CmdW'($urandom_range(1, 3));
        s = base - base / 8 + $urandom_range(base / 4);
        if ($urandom_range(24) == 0) s = base * 3;
        if (s > 4095) s = 4095;
        queue_tick(cmd, SampleW'(s));
        n++;
      end
    end
  endtask

  task automatic queue_noise(input int unsigned count);
    logic [CmdW-1:0]    cmd;
    logic [SampleW-1:0] s;
    for (int unsigned k = 0; k < count; k++) begin
      cmd = ($urandom_range(4) == 0) ? CmdStop : CmdW'($urandom_range(1, 3));
      case ($urandom_range(3))
        0:       s = '0;
        1:       s = '1;
        default: s = SampleW'($urandom);
      endcase
      queue_tick(cmd, s);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: a full-scale sample does not exceed the reset limit.
    queue_tick(CmdStop, 12'd0);
    queue_tick(CmdOpen, 12'd4095);
    queue_tick(CmdClose, 12'd0);
    queue_tick(CmdGoto, 12'd4095);
    queue_tick(CmdStop, 12'd4095);
    drain_guard();

    // Blanking end, a check on an empty history, an equal sample, an adaptive trip,
    // a halted guard ignoring words, an absolute trip right on start and a timeout.
    program_guard(256, 4000, 8, 2, 1);
    queue_tick(CmdOpen, 12'd100);
    queue_tick(CmdOpen, 12'd100);
    queue_tick(CmdOpen, 12'd100);
    queue_tick(CmdClose, 12'd100);
    queue_tick(CmdClose, 12'd100);
    queue_tick(CmdGoto, 12'd300);
    queue_tick(CmdGoto, 12'd4095);
    queue_tick(CmdStop, 12'd0);
    queue_tick(CmdOpen, 12'd4001);
    queue_tick(CmdStop, 12'd0);
    repeat (9) queue_tick(CmdClose, 12'd50);
    drain_guard();

    program_guard($urandom_range(200, 600), $urandom_range(3000, 4095),
                  $urandom_range(100, 300), $urandom_range(0, 8), $urandom_range(1, 4));
    queue_runs(40, 100, 2000);
    drain_guard();

    // One long run with a check on every tick after the first: the history fills and then wraps.
    send_idle_pct = 68;
    program_guard(4095, 4095, 262143, 0, 0);
    queue_tick(CmdStop, SampleW'($urandom));
    repeat (604) queue_tick(CmdW'($urandom_range(1, 3)), SampleW'($urandom_range(256, 4095)));
    drain_guard();

    send_idle_pct = 0;
    stall_pct     = 68;
    program_guard($urandom_range(0, 4095), $urandom_range(2000, 4095),
                  $urandom_range(1, 60), $urandom_range(0, 4), $urandom_range(0, 3));
    queue_noise(30);
    drain_guard();

    send_idle_pct = 37;
    stall_pct     = 37;
    program_guard(0, 0, 262143, 0, 0);
    queue_noise(15);
    drain_guard();

    // A zero timeout trips on every start tick.
    program_guard(4095, 4095, 0, 4095, 1023);
    queue_noise(10);
    drain_guard();

    program_guard($urandom_range(256, 1024), $urandom_range(1000, 4095),
                  $urandom_range(20, 80), $urandom_range(0, 10), $urandom_range(1, 5));
    queue_runs(30, 50, 3000);
    drain_guard();

    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("tb_adaptive_motor_overcurrent_guard_unit passed");
    end else begin
      $display("tb_adaptive_motor_overcurrent_guard_unit failed");
    end
    $finish;
  end

endmodule
